// File: hw/rtl/tipc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tipc_pkg
// Shared types, register indexes and constants of the two-image compositor.
// ----------------------------------------------------------------------------
package tipc_pkg;

    // Fixed field widths.
    localparam int PIX_W    = 16;
    localparam int COORD_W  = 12;
    localparam int Q_W      = 17;
    localparam int GAIN_W   = 33;
    localparam int TILE_W   = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 33;

    // Default coordinate width handed to the top level.
    localparam int COORD_BITS_DEF = 12;

    // Q1.16 constants.
    localparam logic [Q_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q_W-1:0] HALF_Q16 = 17'd32768;

    // Mode register codes.
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_BLEND  = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;
    localparam logic [1:0] MODE_DIFF   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_OFFSET   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_GAIN     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MV_OFFSET   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MV_GAIN     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 4'd7;

    // Operation chosen by the front end for each pixel.
    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_BLEND,
        OP_CHECK,
        OP_DIFF
    } t_op;

    // Input pixel transfer.
    typedef struct packed {
        logic [PIX_W-1:0]   fg_pixel;
        logic [PIX_W-1:0]   mv_pixel;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               frame_start;
    } t_in_item;

    // Result transfer.
    typedef struct packed {
        logic [Q_W-1:0] composite;
        logic [Q_W-1:0] view_min;
        logic [Q_W-1:0] view_max;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]        mode;
        logic [Q_W-1:0]    alpha;
        logic [PIX_W-1:0]  fg_offset;
        logic [GAIN_W-1:0] fg_gain;
        logic [PIX_W-1:0]  mv_offset;
        logic [GAIN_W-1:0] mv_gain;
        logic [TILE_W-1:0] tile_width;
        logic [TILE_W-1:0] tile_height;
    } t_cfg;

    // Classified command queued between front and back.
    typedef struct packed {
        t_op                op;
        logic [PIX_W-1:0]   fg_delta;
        logic [PIX_W-1:0]   mv_delta;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               frame_start;
    } t_cmd;

    // Queue read side seen by the back end.
    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_cmd_q;

endpackage
`default_nettype wire

// File: hw/rtl/tipc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tipc_front
// Accepts pixel transfers, removes the sample offsets, picks the operation
// and holds the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tipc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tipc_pkg::t_cfg    i_cfg,
    input  wire logic              push,
    output logic                   full,
    input  wire tipc_pkg::t_in_item i_in_item,
    input  wire logic              i_cmd_pop,
    output tipc_pkg::t_cmd_q       o_cmd_q
);
    import tipc_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    // Offset removal with floor at zero, and operation decode.
    always_comb begin
        w_cmd = '0;
        w_cmd.fg_delta = (i_in_item.fg_pixel > i_cfg.fg_offset) ?
                         (i_in_item.fg_pixel - i_cfg.fg_offset) : '0;
        w_cmd.mv_delta = (i_in_item.mv_pixel > i_cfg.mv_offset) ?
                         (i_in_item.mv_pixel - i_cfg.mv_offset) : '0;
        w_cmd.pixel_x     = i_in_item.pixel_x;
        w_cmd.pixel_y     = i_in_item.pixel_y;
        w_cmd.frame_start = i_in_item.frame_start;
        unique case (i_cfg.mode)
            MODE_SINGLE: w_cmd.op = OP_SINGLE;
            MODE_BLEND:  w_cmd.op = OP_BLEND;
            MODE_CHECK:  w_cmd.op = OP_CHECK;
            MODE_DIFF:   w_cmd.op = OP_DIFF;
            default:     w_cmd.op = OP_BLEND;
        endcase
    end

    assign full = (r_cnt == 2'(DEPTH));
    assign w_wr = push && !full;
    assign w_rd = i_cmd_pop && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_mem[r_wp] <= w_cmd;
                r_wp        <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    assign o_cmd_q.empty = (r_cnt == '0);
    assign o_cmd_q.cmd   = r_mem[r_rp];

endmodule
`default_nettype wire

// File: hw/rtl/tipc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tipc_back
// Carries out one queued command at a time: gain multiply, clamp, then blend,
// checkerboard tile division or difference with running range, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module tipc_back #(
    parameter int COORD_BITS = tipc_pkg::COORD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tipc_pkg::t_cfg     i_cfg,
    input  wire tipc_pkg::t_cmd_q   i_cmd_q,
    output logic                    o_cmd_pop,
    output logic                    empty,
    input  wire logic               pop,
    output tipc_pkg::t_out_item     o_out_item
);
    import tipc_pkg::*;

    localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int CNT_W = $clog2(CW);
    localparam int REM_W = TILE_W + 1;
    localparam int PROD_W = PIX_W + GAIN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_BLEND,
        ST_SUM,
        ST_DIV,
        ST_PICK,
        ST_EMIT
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic                r_start;
    logic [PIX_W-1:0]    r_df;
    logic [PIX_W-1:0]    r_dm;
    logic [PROD_W-1:0]   r_pf;
    logic [PROD_W-1:0]   r_pm;
    logic [Q_W-1:0]      r_f;
    logic [Q_W-1:0]      r_m;
    logic [2*Q_W-1:0]    r_pa;
    logic [2*Q_W-1:0]    r_pb;
    logic [CW-1:0]       r_dx;
    logic [CW-1:0]       r_dy;
    logic [REM_W-1:0]    r_rx;
    logic [REM_W-1:0]    r_ry;
    logic                r_qx;
    logic                r_qy;
    logic [CNT_W-1:0]    r_cnt;
    logic [Q_W-1:0]      r_comp;
    logic [Q_W-1:0]      r_vmin;
    logic [Q_W-1:0]      r_vmax;
    logic [Q_W-1:0]      r_run_min;
    logic [Q_W-1:0]      r_run_max;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [Q_W-1:0]      w_alpha;
    logic [TILE_W-1:0]   w_tw;
    logic [TILE_W-1:0]   w_th;
    logic [GAIN_W-1:0]   w_sf;
    logic [GAIN_W-1:0]   w_sm;
    logic [Q_W-1:0]      w_fc;
    logic [Q_W-1:0]      w_mc;
    logic [REM_W-1:0]    w_rsx;
    logic [REM_W-1:0]    w_rsy;
    logic                w_gex;
    logic                w_gey;
    logic [2*Q_W:0]      w_sum;
    logic [Q_W-1:0]      w_diff;
    logic [Q_W-1:0]      w_new_min;
    logic [Q_W-1:0]      w_new_max;
    logic                w_out_free;
    logic                w_emit;

    // Alpha is limited to one, a zero tile size counts as one.
    assign w_alpha = (i_cfg.alpha > ONE_Q16) ? ONE_Q16 : i_cfg.alpha;
    assign w_tw    = (i_cfg.tile_width  == '0) ? TILE_W'(1) : i_cfg.tile_width;
    assign w_th    = (i_cfg.tile_height == '0) ? TILE_W'(1) : i_cfg.tile_height;

    // Drop the product fraction and clamp to one.
    assign w_sf = r_pf[PROD_W-1:16];
    assign w_sm = r_pm[PROD_W-1:16];
    assign w_fc = (w_sf > GAIN_W'(ONE_Q16)) ? ONE_Q16 : w_sf[Q_W-1:0];
    assign w_mc = (w_sm > GAIN_W'(ONE_Q16)) ? ONE_Q16 : w_sm[Q_W-1:0];

    // One restoring division step for each coordinate.
    assign w_rsx = {r_rx[REM_W-2:0], r_dx[CW-1]};
    assign w_rsy = {r_ry[REM_W-2:0], r_dy[CW-1]};
    assign w_gex = (w_rsx >= {1'b0, w_tw});
    assign w_gey = (w_rsy >= {1'b0, w_th});

    // Rounded blend sum.
    assign w_sum = (2*Q_W+1)'(r_pa) + (2*Q_W+1)'(r_pb) + (2*Q_W+1)'(HALF_Q16);

    // Absolute difference and the running range it moves.
    assign w_diff    = (r_m >= r_f) ? (r_m - r_f) : (r_f - r_m);
    assign w_new_min = (r_start || (w_diff < r_run_min)) ? w_diff : r_run_min;
    assign w_new_max = (r_start || (w_diff > r_run_max)) ? w_diff : r_run_max;

    assign w_out_free = !r_out_valid || pop;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;
    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_cmd_q.empty;

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_run_min   <= '0;
            r_run_max   <= '0;
        end else begin
            // A new result replaces the one leaving in the same cycle.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_q.empty) begin
                        r_op    <= i_cmd_q.cmd.op;
                        r_start <= i_cmd_q.cmd.frame_start;
                        r_df    <= i_cmd_q.cmd.fg_delta;
                        r_dm    <= i_cmd_q.cmd.mv_delta;
                        r_dx    <= i_cmd_q.cmd.pixel_x[CW-1:0];
                        r_dy    <= i_cmd_q.cmd.pixel_y[CW-1:0];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_pf    <= PROD_W'(r_df) * PROD_W'(i_cfg.fg_gain);
                    r_pm    <= PROD_W'(r_dm) * PROD_W'(i_cfg.mv_gain);
                    r_state <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    r_f  <= w_fc;
                    r_m  <= w_mc;
                    r_rx <= '0;
                    r_ry <= '0;
                    r_cnt <= '0;
                    unique case (r_op) inside
                        OP_SINGLE, OP_BLEND: r_state <= ST_BLEND;
                        OP_CHECK:            r_state <= ST_DIV;
                        OP_DIFF:             r_state <= ST_PICK;
                        default:             r_state <= ST_BLEND;
                    endcase
                end
                ST_BLEND: begin
                    r_pa <= (2*Q_W)'(w_alpha) * (2*Q_W)'(r_f);
                    if (r_op == OP_BLEND) begin
                        r_pb <= (2*Q_W)'(ONE_Q16 - w_alpha) * (2*Q_W)'(r_m);
                    end else begin
                        r_pb <= '0;
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_comp  <= w_sum[Q_W+15:16];
                    r_vmin  <= '0;
                    r_vmax  <= ONE_Q16;
                    r_state <= ST_EMIT;
                end
                ST_DIV: begin
                    r_rx  <= w_gex ? (w_rsx - REM_W'(w_tw)) : w_rsx;
                    r_ry  <= w_gey ? (w_rsy - REM_W'(w_th)) : w_rsy;
                    r_qx  <= w_gex;
                    r_qy  <= w_gey;
                    r_dx  <= r_dx << 1;
                    r_dy  <= r_dy << 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CW - 1)) begin
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (r_op == OP_DIFF) begin
                        r_comp    <= w_diff;
                        r_vmin    <= w_new_min;
                        r_vmax    <= w_new_max;
                        r_run_min <= w_new_min;
                        r_run_max <= w_new_max;
                    end else begin
                        // Same tile parity on both axes shows the foreground.
                        r_comp <= (r_qx == r_qy) ? r_f : r_m;
                        r_vmin <= '0;
                        r_vmax <= ONE_Q16;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out.composite <= r_comp;
                        r_out.view_min  <= r_vmin;
                        r_out.view_max  <= r_vmax;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/two_image_pixel_compositor.sv
`default_nettype none
// In checkerboard mode the back end runs a restoring division over COORD_BITS
// coordinate bits (COORD_BITS capped at 12); the other modes skip it.
// The back-end sequencer works on one pixel at a time and takes no new
// pixel until its result is stored; the front queue holds two more.
// Reset is synchronous and active low; it restores the register defaults,
// empties both queues and clears the running minimum and maximum.
// ----------------------------------------------------------------------------
// two_image_pixel_compositor
// Top level: configuration registers, front end with command queue, and the
// back-end compositing sequencer.
// ----------------------------------------------------------------------------
module two_image_pixel_compositor #(
    parameter int COORD_BITS = tipc_pkg::COORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire tipc_pkg::t_in_item          i_in_item,
    output logic                             empty,
    input  wire logic                        pop,
    output tipc_pkg::t_out_item              o_out_item,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tipc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tipc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tipc_pkg::*;

    t_cfg   r_cfg;
    t_cmd_q w_cmd_q;
    logic   w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_BLEND;
            r_cfg.alpha       <= HALF_Q16;
            r_cfg.fg_offset   <= '0;
            r_cfg.fg_gain     <= GAIN_W'(65537);
            r_cfg.mv_offset   <= '0;
            r_cfg.mv_gain     <= GAIN_W'(65537);
            r_cfg.tile_width  <= TILE_W'(64);
            r_cfg.tile_height <= TILE_W'(64);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_cfg.mode        <= i_cfg_data[1:0];
                CFG_ALPHA:       r_cfg.alpha       <= i_cfg_data[Q_W-1:0];
                CFG_FG_OFFSET:   r_cfg.fg_offset   <= i_cfg_data[PIX_W-1:0];
                CFG_FG_GAIN:     r_cfg.fg_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_MV_OFFSET:   r_cfg.mv_offset   <= i_cfg_data[PIX_W-1:0];
                CFG_MV_GAIN:     r_cfg.mv_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_TILE_WIDTH:  r_cfg.tile_width  <= i_cfg_data[TILE_W-1:0];
                CFG_TILE_HEIGHT: r_cfg.tile_height <= i_cfg_data[TILE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: accept, classify, queue.
    tipc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_cmd_pop (w_cmd_pop),
        .o_cmd_q   (w_cmd_q)
    );

    // Back end: compute and hold results.
    tipc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_q    (w_cmd_q),
        .o_cmd_pop  (w_cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire
